// ===== sv/morse_timing_decoder_assert.svh =====
// Assertion shorthands for the Morse timing decoder.
// Each macro expects clk and rst_n in scope.
`ifndef MORSE_TIMING_DECODER_ASSERT_SVH
`define MORSE_TIMING_DECODER_ASSERT_SVH

// Condition holds at every clock edge outside reset.
`define MTD_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Same-cycle implication.
`define MTD_ASSERT_IMPLIES(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define MTD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/mtd_pkg.sv =====
package mtd_pkg;

    localparam int TIME_BITS = 32;
    typedef logic [TIME_BITS-1:0] time_t;

    // compare widths: spans against thresholds, and the scaled word gap test
    localparam int CMP_W = (TIME_BITS > 16) ? TIME_BITS : 16;
    localparam int GAP_W = TIME_BITS + 12;

    localparam int DOT_W   = 11;
    localparam int THR_W   = 15;
    localparam int AVG_W   = 24;
    localparam int CHAR_W  = 7;
    localparam int Q_DEPTH = 3;
    localparam int Q_CNT_W = 2;

    localparam logic [DOT_W-1:0]  DOT_RESET  = 11'd80;
    localparam logic [15:0]       NEWLINE_MS = 16'd2000;
    localparam logic [15:0]       PAUSE_SAT  = 16'hFFFF;
    localparam logic [CHAR_W-1:0] CH_NONE    = 7'd0;
    localparam logic [CHAR_W-1:0] CH_SPACE   = 7'd32;
    localparam logic [CHAR_W-1:0] CH_NEWLINE = 7'd10;

    // timing limits derived from the dot length, all in ms
    typedef struct packed {
        logic [THR_W-1:0] letter_gap;
        logic [THR_W-1:0] dot_min;
        logic [THR_W-1:0] dot_max;
        logic [THR_W-1:0] dash_min;
        logic [THR_W-1:0] dash_max;
        logic [THR_W-1:0] tone_drop;
        logic [THR_W-1:0] gap_lo;
        logic [THR_W-1:0] gap_mid;
        logic [THR_W-1:0] gap_hi;
        logic [THR_W-1:0] gap_fixed;
    } thr_t;

    typedef struct packed {
        logic [CHAR_W-1:0] char_code;
        logic              last;
    } out_word_t;

    // floor(x/10) for x < 2^18 by reciprocal multiply
    function automatic logic [THR_W-1:0] div10_narrow(input logic [17:0] x);
        logic [35:0] prod;
        prod = 36'(x) * 36'd52429;
        return prod[19 +: THR_W];
    endfunction

    // floor(x/10) for x < 2^28, low 24 bits kept
    function automatic logic [AVG_W-1:0] div10_avg(input logic [27:0] x);
        logic [55:0] prod;
        prod = 56'(x) * 56'd214748365;
        return prod[31 +: AVG_W];
    endfunction

    function automatic thr_t calc_thr(input logic [DOT_W-1:0] d);
        thr_t        t;
        logic [17:0] dx;
        dx          = 18'(d);
        t.letter_gap = THR_W'(dx * 18'd3);
        t.dot_min    = div10_narrow(dx * 18'd7);
        t.dot_max    = div10_narrow(dx * 18'd13);
        t.dash_min   = div10_narrow(dx * 18'd21);
        t.dash_max   = div10_narrow(dx * 18'd39);
        t.tone_drop  = THR_W'({t.dash_max, 1'b0});
        t.gap_lo     = div10_narrow(dx * 18'd54);
        t.gap_mid    = div10_narrow(dx * 18'd66);
        t.gap_hi     = THR_W'(dx * 18'd12);
        t.gap_fixed  = THR_W'(dx * 18'd7);
        return t;
    endfunction

    // leading 1 marks the length, dash = 1, first element most significant
    function automatic logic [5:0] pattern_index(input logic [4:0] bits,
                                                 input logic [2:0] len);
        logic [5:0] idx;
        case (len)
            3'd1:    idx = {5'd1, bits[0]};
            3'd2:    idx = {4'd1, bits[1:0]};
            3'd3:    idx = {3'd1, bits[2:0]};
            3'd4:    idx = {2'd1, bits[3:0]};
            3'd5:    idx = {1'b1, bits[4:0]};
            default: idx = 6'd0;
        endcase
        return idx;
    endfunction

    function automatic logic [CHAR_W-1:0] sym_lookup(input logic [5:0] idx);
        logic [CHAR_W-1:0] c;
        case (idx)
            6'd2:    c = 7'd69;  // E
            6'd3:    c = 7'd84;  // T
            6'd4:    c = 7'd73;  // I
            6'd5:    c = 7'd65;  // A
            6'd6:    c = 7'd78;  // N
            6'd7:    c = 7'd77;  // M
            6'd8:    c = 7'd83;  // S
            6'd9:    c = 7'd85;  // U
            6'd10:   c = 7'd82;  // R
            6'd11:   c = 7'd87;  // W
            6'd12:   c = 7'd68;  // D
            6'd13:   c = 7'd75;  // K
            6'd14:   c = 7'd71;  // G
            6'd15:   c = 7'd79;  // O
            6'd16:   c = 7'd72;  // H
            6'd17:   c = 7'd86;  // V
            6'd18:   c = 7'd70;  // F
            6'd20:   c = 7'd76;  // L
            6'd22:   c = 7'd80;  // P
            6'd23:   c = 7'd74;  // J
            6'd24:   c = 7'd66;  // B
            6'd25:   c = 7'd88;  // X
            6'd26:   c = 7'd67;  // C
            6'd27:   c = 7'd89;  // Y
            6'd28:   c = 7'd90;  // Z
            6'd29:   c = 7'd81;  // Q
            6'd32:   c = 7'd53;  // 5
            6'd33:   c = 7'd52;  // 4
            6'd35:   c = 7'd51;  // 3
            6'd39:   c = 7'd50;  // 2
            6'd47:   c = 7'd49;  // 1
            6'd48:   c = 7'd54;  // 6
            6'd56:   c = 7'd55;  // 7
            6'd60:   c = 7'd56;  // 8
            6'd62:   c = 7'd57;  // 9
            6'd63:   c = 7'd48;  // 0
            default: c = CH_NONE;
        endcase
        return c;
    endfunction

    // span >= word gap, without forming the gap itself: gap_fixed until
    // adapted, then clamp(base, lo, hi), base from Q8 average or gap_mid
    function automatic logic gap_reached(input time_t            span,
                                         input logic [AVG_W-1:0] avg,
                                         input thr_t             thr,
                                         input logic             adapt);
        logic [CMP_W-1:0] s;
        logic [25:0]      avg_lim;
        logic [GAP_W-1:0] avg13;
        logic [GAP_W-1:0] span_lim;
        logic             base_hit;
        logic             hit;
        s        = CMP_W'(span);
        avg_lim  = (26'(thr.letter_gap) << 8) + (26'(thr.letter_gap) << 7);
        avg13    = (GAP_W'(avg) << 3) + (GAP_W'(avg) << 2) + GAP_W'(avg);
        span_lim = (GAP_W'(span) << 11) + (GAP_W'(span) << 9) + GAP_W'(2559);
        if (26'(avg) > avg_lim)
        begin
            base_hit = (avg13 <= span_lim);
        end
        else
        begin
            base_hit = (s >= CMP_W'(thr.gap_mid));
        end
        if (!adapt)
        begin
            hit = (s >= CMP_W'(thr.gap_fixed));
        end
        else
        begin
            hit = (s >= CMP_W'(thr.gap_hi))
                || ((s >= CMP_W'(thr.gap_lo)) && base_hit);
        end
        return hit;
    endfunction

endpackage

// ===== sv/morse_timing_decoder.sv =====
// Morse timing decoder.
// Input channel (in_valid / in_stall): one word per frame, tone_present and
// a wrapping millisecond timestamp time_ms. A word is taken at an edge with
// in_valid high and in_stall low.
// Output channel (out_valid / out_stall): one character per word, char_code
// (letter, digit, 32 space, 10 newline) and last_of_step, set on the final
// character caused by a frame. A frame causes zero, one or two characters.
// Config channel (cfg_valid / cfg_ready / dot_ms): sets the dot length and
// restarts the word gap at seven dots. Ready only while no frame is held.
// Flow: a frame is registered on acceptance and decoded, once the queue holds
// at most one word, into a three-word output queue; its characters are
// registered there, behind any characters still waiting.
// Throughput: one frame per cycle while the queue holds at most one word;
// with two or more queued the frame register waits, so a two-character
// frame holds the next back. A stalled receiver backs up into in_stall.
// Reset: asynchronous, active low. Phase idle, pattern empty, dot 80 ms,
// word gap 560 ms, queue empty.
`include "morse_timing_decoder_assert.svh"

module morse_timing_decoder import mtd_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic              tone_present,
    input  logic [31:0]       time_ms,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [CHAR_W-1:0] char_code,
    output logic              last_of_step,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [DOT_W-1:0]  dot_ms
);

    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,
        PH_TONE  = 2'd1,
        PH_PAUSE = 2'd2
    } phase_t;

    // frame register
    logic             in_valid_reg, in_valid_next;
    logic             tone_reg, tone_next;
    time_t            time_reg, time_next;

    // decoder state
    thr_t             thr_reg, thr_next;
    phase_t           phase_reg, phase_next;
    time_t            tone_start_reg, tone_start_next;
    time_t            tone_end_reg, tone_end_next;
    logic             armed_reg, armed_next;
    logic             wsd_reg, wsd_next;
    logic [4:0]       pat_bits_reg, pat_bits_next;
    logic [2:0]       pat_len_reg, pat_len_next;
    logic [AVG_W-1:0] avg_reg, avg_next;
    logic             first_pause_reg, first_pause_next;
    logic             gap_adapt_reg, gap_adapt_next;

    // output queue, head at entry 0
    out_word_t        q_reg [Q_DEPTH];
    out_word_t        q_next [Q_DEPTH];
    out_word_t        q_shift [Q_DEPTH];
    logic [Q_CNT_W-1:0] q_cnt_reg, q_cnt_next;
    logic [Q_CNT_W-1:0] q_base;

    logic             process;
    logic             pop;
    logic             cfg_we;

    // step results
    logic [CHAR_W-1:0] res0, res1;
    logic [1:0]        res_n;
    out_word_t         w0, w1;

    // step datapath
    time_t             dur;
    time_t             gap_span;
    logic [CMP_W-1:0]  d;
    logic [CMP_W-1:0]  dist_lo, dist_hi;
    logic [CHAR_W-1:0] held_char;
    logic [4:0]        base_bits;
    logic [2:0]        base_len;
    logic              add_el;
    logic              el_dash;
    logic [15:0]       pause_sat;
    logic [AVG_W-1:0]  pause_q8;
    logic [27:0]       avg_sum;
    logic [AVG_W-1:0]  avg_upd;

    assign process   = in_valid_reg && (q_cnt_reg <= Q_CNT_W'(1));
    assign pop       = (q_cnt_reg != '0) && !out_stall;
    assign cfg_we    = cfg_valid && cfg_ready;

    assign in_stall  = in_valid_reg && (q_cnt_reg > Q_CNT_W'(1));
    assign cfg_ready = !in_valid_reg;
    assign out_valid = (q_cnt_reg != '0);
    assign char_code    = q_reg[0].char_code;
    assign last_of_step = q_reg[0].last;

    assign dur       = time_reg - tone_start_reg;
    assign gap_span  = time_reg - tone_end_reg;
    assign d         = CMP_W'(dur);
    assign dist_lo   = d - CMP_W'(thr_reg.dot_max);
    assign dist_hi   = CMP_W'(thr_reg.dash_min) - d;
    assign held_char = sym_lookup(pattern_index(pat_bits_reg, pat_len_reg));

    assign pause_sat = (CMP_W'(gap_span) > CMP_W'(PAUSE_SAT)) ? PAUSE_SAT
                                                              : gap_span[15:0];
    assign pause_q8  = {pause_sat, 8'd0};
    // 7*avg + 3*pause_q8, then /10
    assign avg_sum   = (28'(avg_reg) << 3) - 28'(avg_reg)
                     + (28'(pause_q8) << 1) + 28'(pause_q8);
    assign avg_upd   = first_pause_reg ? div10_avg(avg_sum) : pause_q8;

    // frame register loads whenever it is not held back
    always_comb
    begin
        in_valid_next = in_valid_reg;
        tone_next     = tone_reg;
        time_next     = time_reg;
        if (!in_stall)
        begin
            in_valid_next = in_valid;
            tone_next     = tone_present;
            time_next     = time_t'(time_ms);
        end
    end

    // one frame through the idle / tone / pause machine, plus config writes
    always_comb
    begin
        thr_next         = thr_reg;
        phase_next       = phase_reg;
        tone_start_next  = tone_start_reg;
        tone_end_next    = tone_end_reg;
        armed_next       = armed_reg;
        wsd_next         = wsd_reg;
        pat_bits_next    = pat_bits_reg;
        pat_len_next     = pat_len_reg;
        avg_next         = avg_reg;
        first_pause_next = first_pause_reg;
        gap_adapt_next   = gap_adapt_reg;
        res0             = CH_NONE;
        res1             = CH_NONE;
        res_n            = 2'd0;
        base_bits        = pat_bits_reg;
        base_len         = pat_len_reg;
        add_el           = 1'b0;
        el_dash          = 1'b0;

        if (process)
        begin
            case (phase_reg)
                PH_TONE:
                begin
                    if (!tone_reg)
                    begin
                        tone_end_next = time_reg;
                        armed_next    = 1'b1;
                        phase_next    = PH_PAUSE;
                        // a full pattern is flushed before the new element
                        if (pat_len_reg >= 3'd5)
                        begin
                            if (held_char == CH_NONE)
                            begin
                                phase_next      = PH_IDLE;
                                tone_start_next = '0;
                            end
                            else
                            begin
                                res0  = held_char;
                                res_n = 2'd1;
                            end
                            base_bits     = '0;
                            base_len      = '0;
                            pat_bits_next = '0;
                            pat_len_next  = '0;
                        end
                        if ((d >= CMP_W'(thr_reg.dot_min)) && (d <= CMP_W'(thr_reg.dot_max)))
                        begin
                            add_el = 1'b1;
                        end
                        else if ((d >= CMP_W'(thr_reg.dash_min))
                                 && (d <= CMP_W'(thr_reg.dash_max)))
                        begin
                            add_el  = 1'b1;
                            el_dash = 1'b1;
                        end
                        else if ((d > CMP_W'(thr_reg.dot_max)) && (d < CMP_W'(thr_reg.dash_min)))
                        begin
                            // between windows: nearer limit, tie to dot
                            add_el  = 1'b1;
                            el_dash = (dist_lo > dist_hi);
                        end
                        else if (d > CMP_W'(thr_reg.tone_drop))
                        begin
                            pat_bits_next   = '0;
                            pat_len_next    = '0;
                            phase_next      = PH_IDLE;
                            tone_start_next = '0;
                        end
                        if (add_el)
                        begin
                            pat_bits_next = {base_bits[3:0], el_dash};
                            pat_len_next  = base_len + 3'd1;
                        end
                    end
                end
                PH_PAUSE:
                begin
                    if (tone_reg)
                    begin
                        tone_start_next = time_reg;
                        phase_next      = PH_TONE;
                    end
                    else if (CMP_W'(gap_span) >= CMP_W'(thr_reg.letter_gap))
                    begin
                        if (pat_len_reg != 3'd0)
                        begin
                            if (held_char == CH_NONE)
                            begin
                                tone_start_next = '0;
                            end
                            else
                            begin
                                res0  = held_char;
                                res_n = 2'd1;
                            end
                        end
                        pat_bits_next    = '0;
                        pat_len_next     = '0;
                        avg_next         = avg_upd;
                        first_pause_next = 1'b1;
                        gap_adapt_next   = 1'b1;
                        // space test uses the freshly updated word gap
                        if (gap_reached(gap_span, avg_upd, thr_reg, 1'b1))
                        begin
                            if (res_n == 2'd0)
                            begin
                                res0 = CH_SPACE;
                            end
                            else
                            begin
                                res1 = CH_SPACE;
                            end
                            res_n = res_n + 2'd1;
                        end
                        phase_next = PH_IDLE;
                    end
                end
                default:
                begin
                    // idle; the unused phase code behaves the same
                    if (tone_reg)
                    begin
                        tone_start_next = time_reg;
                        phase_next      = PH_TONE;
                        wsd_next        = 1'b0;
                    end
                    else if (armed_reg)
                    begin
                        if (CMP_W'(gap_span) >= CMP_W'(NEWLINE_MS))
                        begin
                            res0       = CH_NEWLINE;
                            res_n      = 2'd1;
                            armed_next = 1'b0;
                        end
                        else if (!wsd_reg
                                 && gap_reached(gap_span, avg_reg, thr_reg, gap_adapt_reg))
                        begin
                            res0     = CH_SPACE;
                            res_n    = 2'd1;
                            wsd_next = 1'b1;
                        end
                    end
                end
            endcase
        end

        if (cfg_we)
        begin
            thr_next       = calc_thr(dot_ms);
            gap_adapt_next = 1'b0;
        end
    end

    // queue: shift on pop, append this step's words behind the survivors
    always_comb
    begin
        w0.char_code = res0;
        w0.last      = (res_n == 2'd1);
        w1.char_code = res1;
        w1.last      = 1'b1;
        q_base       = q_cnt_reg - Q_CNT_W'(pop);
        for (int i = 0; i < Q_DEPTH; i++)
        begin
            if (pop && (i < Q_DEPTH - 1))
            begin
                q_shift[i] = q_reg[i + 1];
            end
            else
            begin
                q_shift[i] = q_reg[i];
            end
        end
        for (int i = 0; i < Q_DEPTH; i++)
        begin
            q_next[i] = q_shift[i];
            if ((res_n != 2'd0) && (Q_CNT_W'(i) == q_base))
            begin
                q_next[i] = w0;
            end
            if ((res_n == 2'd2) && (Q_CNT_W'(i) == q_base + Q_CNT_W'(1)))
            begin
                q_next[i] = w1;
            end
        end
        q_cnt_next = q_base + Q_CNT_W'(res_n);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg    <= 1'b0;
            tone_reg        <= 1'b0;
            time_reg        <= '0;
            thr_reg         <= calc_thr(DOT_RESET);
            phase_reg       <= PH_IDLE;
            tone_start_reg  <= '0;
            tone_end_reg    <= '0;
            armed_reg       <= 1'b0;
            wsd_reg         <= 1'b0;
            pat_bits_reg    <= '0;
            pat_len_reg     <= '0;
            avg_reg         <= '0;
            first_pause_reg <= 1'b0;
            gap_adapt_reg   <= 1'b0;
            q_cnt_reg       <= '0;
            for (int i = 0; i < Q_DEPTH; i++)
            begin
                q_reg[i] <= '0;
            end
        end
        else
        begin
            in_valid_reg    <= in_valid_next;
            tone_reg        <= tone_next;
            time_reg        <= time_next;
            thr_reg         <= thr_next;
            phase_reg       <= phase_next;
            tone_start_reg  <= tone_start_next;
            tone_end_reg    <= tone_end_next;
            armed_reg       <= armed_next;
            wsd_reg         <= wsd_next;
            pat_bits_reg    <= pat_bits_next;
            pat_len_reg     <= pat_len_next;
            avg_reg         <= avg_next;
            first_pause_reg <= first_pause_next;
            gap_adapt_reg   <= gap_adapt_next;
            q_cnt_reg       <= q_cnt_next;
            for (int i = 0; i < Q_DEPTH; i++)
            begin
                q_reg[i] <= q_next[i];
            end
        end
    end

    `MTD_ASSERT_ALWAYS(a_pat_len_max, pat_len_reg <= 3'd5, "pattern longer than five")
    `MTD_ASSERT_IMPLIES(a_pause_armed, phase_reg == PH_PAUSE, armed_reg,
                        "pause phase without a tone end")
    `MTD_ASSERT_IMPLIES(a_queue_tail_last, q_cnt_reg != '0,
                        q_reg[Q_CNT_W'(q_cnt_reg - Q_CNT_W'(1))].last,
                        "queue tail is not the end of a step")
    `MTD_ASSERT_NEXT(a_cfg_fixed_gap, cfg_we, !gap_adapt_reg,
                     "config write did not reload the word gap")
    `MTD_ASSERT_NEXT(a_pop_count, pop && !process,
                     q_cnt_reg == $past(q_cnt_reg) - Q_CNT_W'(1),
                     "queue count off after pop")

endmodule
